// ----- rtl/core/y86ex_pkg.sv -----
// ----------------------------------------------------------------------------
// y86ex_pkg
// Shared codes, field widths and beat layouts for the Y86-64 execute stage.
// ----------------------------------------------------------------------------
package y86ex_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned CodeW   = 4;
  localparam int unsigned StatW   = 2;
  localparam int unsigned InDataW  = 216;
  localparam int unsigned OutDataW = 144;

  // Instruction codes.
  localparam logic [CodeW-1:0] OP_HALT  = 4'd0;
  localparam logic [CodeW-1:0] OP_NOP   = 4'd1;
  localparam logic [CodeW-1:0] OP_RRMOV = 4'd2;
  localparam logic [CodeW-1:0] OP_IRMOV = 4'd3;
  localparam logic [CodeW-1:0] OP_RMMOV = 4'd4;
  localparam logic [CodeW-1:0] OP_MRMOV = 4'd5;
  localparam logic [CodeW-1:0] OP_ALU   = 4'd6;
  localparam logic [CodeW-1:0] OP_JUMP  = 4'd7;
  localparam logic [CodeW-1:0] OP_CALL  = 4'd8;
  localparam logic [CodeW-1:0] OP_RET   = 4'd9;
  localparam logic [CodeW-1:0] OP_PUSH  = 4'd10;
  localparam logic [CodeW-1:0] OP_POP   = 4'd11;
  localparam logic [CodeW-1:0] OP_IADD  = 4'd12;

  // ALU function codes.
  localparam logic [CodeW-1:0] ALU_ADD = 4'd0;
  localparam logic [CodeW-1:0] ALU_SUB = 4'd1;
  localparam logic [CodeW-1:0] ALU_AND = 4'd2;

  // Condition function codes.
  localparam logic [CodeW-1:0] CND_ALWAYS = 4'd0;
  localparam logic [CodeW-1:0] CND_LE     = 4'd1;
  localparam logic [CodeW-1:0] CND_L      = 4'd2;
  localparam logic [CodeW-1:0] CND_E      = 4'd3;
  localparam logic [CodeW-1:0] CND_NE     = 4'd4;
  localparam logic [CodeW-1:0] CND_GE     = 4'd5;
  localparam logic [CodeW-1:0] CND_G      = 4'd6;

  localparam logic [StatW-1:0] STAT_AOK = 2'd0;
  localparam logic [CodeW-1:0] REG_NONE = 4'd15;

  typedef struct packed {
    logic zf;
    logic sf;
    logic of;
  } cc_t;

  // Input beat, listed from the highest bits down.
  typedef struct packed {
    logic [1:0]       pad;
    logic [StatW-1:0] wb_stat;
    logic [StatW-1:0] mem_stat;
    logic [CodeW-1:0] dst_m;
    logic [CodeW-1:0] dst_e;
    logic [WordW-1:0] val_b;
    logic [WordW-1:0] val_a;
    logic [WordW-1:0] val_c;
    logic [CodeW-1:0] ifun;
    logic [CodeW-1:0] icode;
    logic [StatW-1:0] stat;
  } in_beat_t;

  // Output beat, listed from the highest bits down.
  typedef struct packed {
    logic             bubble;
    logic [CodeW-1:0] dst_m;
    logic [CodeW-1:0] dst_e;
    logic [WordW-1:0] val_a;
    logic [WordW-1:0] val_e;
    logic             cnd;
    logic [CodeW-1:0] icode;
    logic [StatW-1:0] stat;
  } out_beat_t;

endpackage

// ----- rtl/core/y86_execute_stage_top.sv -----
// ----------------------------------------------------------------------------
// y86_execute_stage_top
// Execute stage of the Y86-64 pipeline with iaddq, as a streaming block.
// ----------------------------------------------------------------------------
// Each input beat carries one execute-register entry plus the current memory
// and writeback status codes; each output beat is the matching memory-register
// entry. The block is two registers deep: an input register and a result
// register with the operand muxes, the 64-bit ALU and the condition logic
// between them. A beat is accepted every cycle while results are taken. A
// result beat is presented once its entry moves from the input register into
// the result register, which waits while a presented result is stalled.
// The condition flags (ZF, SF, OF) sit in one register that is updated in the
// same cycle an entry moves into the result register, so the next entry always
// sees the flags left by the one before it. After reset ZF is set and SF, OF
// are clear.
module y86_execute_stage_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata fields from bit 0 up: in_status(2), opcode(4), function_code(4),
  // constant_word(64), operand_a(64), operand_b(64), dest_e(4), dest_m(4),
  // memory_status(2), writeback_status(2), zero fill(2).
  input  logic [y86ex_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata fields from bit 0 up: out_status(2), out_opcode(4),
  // condition_met(1), result_value(64), passed_a(64), out_dest_e(4),
  // out_dest_m(4), bubble_memory(1).
  output logic [y86ex_pkg::OutDataW-1:0]     m_axis_tdata
);

  // Input register.
  logic                 in_vld_q;
  y86ex_pkg::in_beat_t  in_q;
  // Result register.
  logic                 out_vld_q;
  y86ex_pkg::out_beat_t out_q, out_d;
  // Flags.
  y86ex_pkg::cc_t       cc_q, cc_d;

  logic                 out_free;
  logic                 advance;

  logic [y86ex_pkg::WordW-1:0] alu_a, alu_b, val_e;
  logic [y86ex_pkg::CodeW-1:0] alu_fun;
  logic                        cnd, lt, ovf, exc, set_cc;

  // Handshake: the result register frees when empty or being taken, and the
  // input register refills whenever its entry moves on.
  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cc_q      <= '{zf: 1'b1, sf: 1'b0, of: 1'b0};
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      cc_q <= cc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= y86ex_pkg::in_beat_t'(s_axis_tdata);
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Condition evaluation from the flags as they stand before this entry.
  assign lt = cc_q.sf ^ cc_q.of;

  always_comb begin
    cnd = 1'b0;
    if (in_q.icode == y86ex_pkg::OP_RRMOV || in_q.icode == y86ex_pkg::OP_JUMP) begin
      unique case (in_q.ifun)
        y86ex_pkg::CND_ALWAYS: cnd = 1'b1;
        y86ex_pkg::CND_LE:     cnd = lt | cc_q.zf;
        y86ex_pkg::CND_L:      cnd = lt;
        y86ex_pkg::CND_E:      cnd = cc_q.zf;
        y86ex_pkg::CND_NE:     cnd = !cc_q.zf;
        y86ex_pkg::CND_GE:     cnd = !lt;
        y86ex_pkg::CND_G:      cnd = !lt && !cc_q.zf;
        default:               cnd = 1'b0;
      endcase
    end
  end

  // Operand muxes.
  always_comb begin
    unique case (in_q.icode)
      y86ex_pkg::OP_RRMOV, y86ex_pkg::OP_ALU: alu_a = in_q.val_a;
      y86ex_pkg::OP_IRMOV, y86ex_pkg::OP_RMMOV,
      y86ex_pkg::OP_MRMOV, y86ex_pkg::OP_IADD: alu_a = in_q.val_c;
      y86ex_pkg::OP_CALL, y86ex_pkg::OP_PUSH:  alu_a = -64'sd8;
      y86ex_pkg::OP_RET, y86ex_pkg::OP_POP:    alu_a = 64'd8;
      default:                                 alu_a = '0;
    endcase
    unique case (in_q.icode)
      y86ex_pkg::OP_RMMOV, y86ex_pkg::OP_MRMOV, y86ex_pkg::OP_ALU,
      y86ex_pkg::OP_CALL, y86ex_pkg::OP_PUSH, y86ex_pkg::OP_RET,
      y86ex_pkg::OP_POP, y86ex_pkg::OP_IADD:   alu_b = in_q.val_b;
      default:                                 alu_b = '0;
    endcase
  end

  // ALU. Anything but OPq adds; unknown OPq functions act as xor.
  assign alu_fun = (in_q.icode == y86ex_pkg::OP_ALU) ? in_q.ifun : y86ex_pkg::ALU_ADD;

  always_comb begin
    unique case (alu_fun)
      y86ex_pkg::ALU_ADD: begin
        val_e = alu_b + alu_a;
        ovf   = (alu_a[63] ~^ alu_b[63]) & (val_e[63] ^ alu_b[63]);
      end
      y86ex_pkg::ALU_SUB: begin
        val_e = alu_b - alu_a;
        ovf   = (alu_a[63] ^ alu_b[63]) & (val_e[63] ^ alu_b[63]);
      end
      y86ex_pkg::ALU_AND: begin
        val_e = alu_a & alu_b;
        ovf   = 1'b0;
      end
      default: begin
        val_e = alu_a ^ alu_b;
        ovf   = 1'b0;
      end
    endcase
  end

  // Flags change only for OPq and iaddq while no later stage has faulted.
  assign exc    = (in_q.mem_stat != y86ex_pkg::STAT_AOK) ||
                  (in_q.wb_stat != y86ex_pkg::STAT_AOK);
  assign set_cc = advance && !exc &&
                  (in_q.icode == y86ex_pkg::OP_ALU || in_q.icode == y86ex_pkg::OP_IADD);

  always_comb begin
    cc_d = cc_q;
    if (set_cc) begin
      cc_d.zf = (val_e == '0);
      cc_d.sf = val_e[63];
      cc_d.of = ovf;
    end
  end

  always_comb begin
    out_d.stat   = in_q.stat;
    out_d.icode  = in_q.icode;
    out_d.cnd    = cnd;
    out_d.val_e  = val_e;
    out_d.val_a  = in_q.val_a;
    out_d.dst_e  = (in_q.icode == y86ex_pkg::OP_RRMOV && !cnd) ? y86ex_pkg::REG_NONE
                                                               : in_q.dst_e;
    out_d.dst_m  = in_q.dst_m;
    out_d.bubble = exc;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- rtl/core/y86ex_checker.sv -----
// ----------------------------------------------------------------------------
// y86ex_checker
// Port-level checks for the execute stage, bound to the top level.
// ----------------------------------------------------------------------------
module y86ex_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [y86ex_pkg::OutDataW-1:0] m_axis_tdata
);

  y86ex_pkg::out_beat_t ob;
  assign ob = y86ex_pkg::out_beat_t'(m_axis_tdata);

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // With no result beat waiting, the input side is always open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while no result was waiting");

  // Only moves and jumps can report a met condition.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ob.cnd |->
      (ob.icode == y86ex_pkg::OP_RRMOV || ob.icode == y86ex_pkg::OP_JUMP))
    else $error("condition set for non-branch instruction");

  // A failed conditional move writes no register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ob.icode == y86ex_pkg::OP_RRMOV && !ob.cnd |->
      ob.dst_e == y86ex_pkg::REG_NONE)
    else $error("failed cmov kept its destination");

  // Instructions without ALU operands produce a zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (ob.icode == y86ex_pkg::OP_HALT || ob.icode == y86ex_pkg::OP_NOP ||
                      ob.icode == y86ex_pkg::OP_JUMP || ob.icode > y86ex_pkg::OP_IADD) |->
      ob.val_e == '0)
    else $error("nonzero result for an instruction without operands");

endmodule

bind y86_execute_stage_top y86ex_checker u_y86ex_checker (.*);

// ----- tb/exec_stage_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exec_stage_monitor
// Watches both streams of the execute stage, predicts each memory-register
// entry from the accepted input beats and compares it with the result beats.
// ----------------------------------------------------------------------------
module exec_stage_monitor
  import y86ex_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam logic [WordW-1:0] STACK_DOWN = 64'hFFFF_FFFF_FFFF_FFF8;
  localparam logic [WordW-1:0] STACK_UP   = 64'd8;
  localparam int unsigned      ReportMax  = 10;

  cc_t         flags;
  out_beat_t   memory_entries_q[$];
  int unsigned fail_count;

  // Computes the memory-register entry for one execute entry. The condition
  // uses the flags as they stand; cc_out holds the flags after this entry.
  function automatic out_beat_t execute_entry(input in_beat_t e, input cc_t cc_in,
                                              output cc_t cc_out);
    out_beat_t        res;
    logic [WordW-1:0] op_a;
    logic [WordW-1:0] op_b;
    logic [WordW-1:0] val_e;
    logic [CodeW-1:0] alu_fn;
    logic             lt;
    logic             taken;
    logic             ovf;
    logic             exc;

    exc    = (e.mem_stat != STAT_AOK) || (e.wb_stat != STAT_AOK);
    alu_fn = (e.icode == OP_ALU) ? e.ifun : ALU_ADD;

    case (e.icode)
      OP_RRMOV, OP_ALU:                      op_a = e.val_a;
      OP_IRMOV, OP_RMMOV, OP_MRMOV, OP_IADD: op_a = e.val_c;
      OP_CALL, OP_PUSH:                      op_a = STACK_DOWN;
      OP_RET, OP_POP:                        op_a = STACK_UP;
      default:                               op_a = '0;
    endcase
    case (e.icode)
      OP_RMMOV, OP_MRMOV, OP_ALU, OP_CALL, OP_PUSH, OP_RET, OP_POP, OP_IADD:
        op_b = e.val_b;
      default:
        op_b = '0;
    endcase

    lt    = cc_in.sf ^ cc_in.of;
    taken = 1'b0;
    if (e.icode == OP_RRMOV || e.icode == OP_JUMP) begin
      case (e.ifun)
        CND_ALWAYS: taken = 1'b1;
        CND_LE:     taken = lt | cc_in.zf;
        CND_L:      taken = lt;
        CND_E:      taken = cc_in.zf;
        CND_NE:     taken = ~cc_in.zf;
        CND_GE:     taken = ~lt;
        CND_G:      taken = ~lt & ~cc_in.zf;
        default:    taken = 1'b0;
      endcase
    end

    // Any function code past AND behaves as xor and never overflows.
    case (alu_fn)
      ALU_ADD: val_e = op_a + op_b;
      ALU_SUB: val_e = op_b - op_a;
      ALU_AND: val_e = op_a & op_b;
      default: val_e = op_a ^ op_b;
    endcase

    ovf = 1'b0;
    if (alu_fn == ALU_ADD) begin
      ovf = (op_a[WordW-1] ^ val_e[WordW-1]) & (op_b[WordW-1] ^ val_e[WordW-1]);
    end else if (alu_fn == ALU_SUB) begin
      ovf = (op_a[WordW-1] ^ op_b[WordW-1]) & (op_b[WordW-1] ^ val_e[WordW-1]);
    end

    cc_out = cc_in;
    if ((e.icode == OP_ALU || e.icode == OP_IADD) && !exc) begin
      cc_out = '{zf: (val_e == '0), sf: val_e[WordW-1], of: ovf};
    end

    res        = '0;
    res.stat   = e.stat;
    res.icode  = e.icode;
    res.cnd    = taken;
    res.val_e  = val_e;
    res.val_a  = e.val_a;
    res.dst_e  = (e.icode == OP_RRMOV && !taken) ? REG_NONE : e.dst_e;
    res.dst_m  = e.dst_m;
    res.bubble = exc;
    return res;
  endfunction

  // The result side is handled before the input side so that a result is
  // always matched against entries accepted at earlier edges.
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t got;
    out_beat_t want;
    out_beat_t predicted;
    cc_t       next_flags;
    if (!rst_ni) begin
      flags = '{zf: 1'b1, sf: 1'b0, of: 1'b0};
      memory_entries_q.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = out_beat_t'(m_tdata_i);
        if (memory_entries_q.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportMax) begin
            $display("unexpected result beat with nothing pending: %h", m_tdata_i);
          end
        end else begin
          want = memory_entries_q.pop_front();
          if (got.stat !== want.stat || got.icode !== want.icode ||
              got.cnd !== want.cnd || got.val_e !== want.val_e ||
              got.val_a !== want.val_a || got.dst_e !== want.dst_e ||
              got.dst_m !== want.dst_m || got.bubble !== want.bubble) begin
            fail_count++;
            if (fail_count <= ReportMax) begin
              $display("mismatch: exp st=%0d op=%0d cnd=%0b valE=%h valA=%h dE=%0d dM=%0d bub=%0b",
                       want.stat, want.icode, want.cnd, want.val_e, want.val_a,
                       want.dst_e, want.dst_m, want.bubble);
              $display("          got st=%0d op=%0d cnd=%0b valE=%h valA=%h dE=%0d dM=%0d bub=%0b",
                       got.stat, got.icode, got.cnd, got.val_e, got.val_a,
                       got.dst_e, got.dst_m, got.bubble);
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        predicted = execute_entry(in_beat_t'(s_tdata_i), flags, next_flags);
        memory_entries_q.push_back(predicted);
        flags = next_flags;
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= memory_entries_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the execute stage with a directed set of entries and then random
// ones under bursty input and a stalling output, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import y86ex_pkg::*;

  // Status codes beyond the one the package names.
  localparam logic [StatW-1:0] STAT_HLT = 2'd1;
  localparam logic [StatW-1:0] STAT_ADR = 2'd2;
  localparam logic [StatW-1:0] STAT_INS = 2'd3;

  // Function codes outside the defined sets.
  localparam logic [CodeW-1:0] ALU_BAD = 4'd15;
  localparam logic [CodeW-1:0] CND_BAD = 4'd9;

  localparam logic [WordW-1:0] WORD_ONES    = '1;
  localparam logic [WordW-1:0] WORD_MIN_NEG = {1'b1, {(WordW-1){1'b0}}};
  localparam logic [WordW-1:0] WORD_MAX_POS = {1'b0, {(WordW-1){1'b1}}};

  localparam int unsigned RandomItems = 800;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 8;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tready = 1'b0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;

  // Receiver stall pattern: a 16-bit mask rotated every cycle and reloaded
  // now and then; an all-ones mask gives stretches without stalls.
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned pattern_left  = 0;

  y86_execute_stage_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  exec_stage_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = 16'hFFFF;
        1:       ready_pattern = 16'hF0F0;
        2:       ready_pattern = 16'($urandom) | 16'h0101;
        default: ready_pattern = 16'h8000 | 16'($urandom_range(0, 255));
      endcase
      pattern_left = $urandom_range(8, 80);
    end else begin
      pattern_left--;
    end
    ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
    m_axis_tready <= ready_pattern[0];
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Operand values lean toward the edges of the 64-bit range.
  function automatic logic [WordW-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WORD_ONES;
      2:       return WORD_MIN_NEG;
      3:       return WORD_MAX_POS;
      4:       return WordW'($urandom_range(0, 16));
      5:       return -WordW'($urandom_range(1, 16));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_beat_t make_entry(input logic [StatW-1:0] stat,
                                          input logic [CodeW-1:0] icode,
                                          input logic [CodeW-1:0] ifun,
                                          input logic [WordW-1:0] val_c,
                                          input logic [WordW-1:0] val_a,
                                          input logic [WordW-1:0] val_b,
                                          input logic [StatW-1:0] mem_stat,
                                          input logic [StatW-1:0] wb_stat);
    in_beat_t e;
    e          = '0;
    e.stat     = stat;
    e.icode    = icode;
    e.ifun     = ifun;
    e.val_c    = val_c;
    e.val_a    = val_a;
    e.val_b    = val_b;
    e.dst_e    = CodeW'($urandom);
    e.dst_m    = CodeW'($urandom);
    e.mem_stat = mem_stat;
    e.wb_stat  = wb_stat;
    return e;
  endfunction

  // Most random entries are flag-setting ops, cmovs and jumps with clean
  // later-stage status, so that conditions see a wide spread of flag values.
  function automatic in_beat_t random_entry();
    in_beat_t    e;
    int unsigned pick;
    e    = '0;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      e.icode = OP_ALU;
    end else if (pick < 42) begin
      e.icode = OP_IADD;
    end else if (pick < 57) begin
      e.icode = OP_RRMOV;
    end else if (pick < 72) begin
      e.icode = OP_JUMP;
    end else begin
      e.icode = CodeW'($urandom_range(0, 15));
    end
    if (e.icode == OP_ALU) begin
      e.ifun = ($urandom_range(0, 9) < 8) ? CodeW'($urandom_range(0, 3)) : CodeW'($urandom);
    end else begin
      e.ifun = ($urandom_range(0, 9) < 8) ? CodeW'($urandom_range(0, 6)) : CodeW'($urandom);
    end
    e.val_c    = random_word();
    e.val_a    = random_word();
    // Equal operands now and then so that sub and xor give zero.
    e.val_b    = ($urandom_range(0, 9) == 0) ? e.val_a : random_word();
    e.stat     = ($urandom_range(0, 9) < 8) ? STAT_AOK : StatW'($urandom_range(1, 3));
    e.mem_stat = ($urandom_range(0, 19) < 17) ? STAT_AOK : StatW'($urandom_range(1, 3));
    e.wb_stat  = ($urandom_range(0, 19) < 17) ? STAT_AOK : StatW'($urandom_range(1, 3));
    e.dst_e    = ($urandom_range(0, 7) == 0) ? REG_NONE : CodeW'($urandom);
    e.dst_m    = ($urandom_range(0, 7) == 0) ? REG_NONE : CodeW'($urandom);
    return e;
  endfunction

  initial begin
    in_beat_t    directed_q[$];
    in_beat_t    item;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned total;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero result sets ZF, then conditions are read back after each flag change.
    directed_q.push_back(make_entry(STAT_AOK, OP_ALU, ALU_ADD, random_word(), WORD_ONES,
                                    64'd1, STAT_AOK, STAT_AOK));
    directed_q.push_back(make_entry(STAT_AOK, OP_JUMP, CND_E, random_word(), random_word(),
                                    random_word(), STAT_AOK, STAT_AOK));
    // Positive overflow on add: SF and OF both set.
    directed_q.push_back(make_entry(STAT_AOK, OP_ALU, ALU_ADD, random_word(), WORD_MAX_POS,
                                    64'd1, STAT_AOK, STAT_AOK));
    directed_q.push_back(make_entry(STAT_AOK, OP_RRMOV, CND_G, random_word(), random_word(),
                                    random_word(), STAT_AOK, STAT_AOK));
    // Overflow on sub (B minus A): OF set with SF clear, so less-than holds.
    directed_q.push_back(make_entry(STAT_AOK, OP_ALU, ALU_SUB, random_word(), 64'd1,
                                    WORD_MIN_NEG, STAT_AOK, STAT_AOK));
    directed_q.push_back(make_entry(STAT_AOK, OP_JUMP, CND_L, random_word(), random_word(),
                                    random_word(), STAT_AOK, STAT_AOK));
    // Unknown condition codes are false; the cmov loses its destination.
    directed_q.push_back(make_entry(STAT_AOK, OP_JUMP, CND_BAD, random_word(), random_word(),
                                    random_word(), STAT_AOK, STAT_AOK));
    directed_q.push_back(make_entry(STAT_AOK, OP_RRMOV, CND_BAD, random_word(), random_word(),
                                    random_word(), STAT_AOK, STAT_AOK));
    directed_q.push_back(make_entry(STAT_AOK, OP_ALU, ALU_AND, random_word(), '0,
                                    WORD_ONES, STAT_AOK, STAT_AOK));
    // Unknown ALU op computes xor.
    directed_q.push_back(make_entry(STAT_AOK, OP_ALU, ALU_BAD, random_word(), random_word(),
                                    random_word(), STAT_AOK, STAT_AOK));
    directed_q.push_back(make_entry(STAT_AOK, OP_IADD, ALU_ADD, WORD_MIN_NEG, random_word(),
                                    WORD_MIN_NEG, STAT_AOK, STAT_AOK));
    // Exception status in a later stage: bubble, and the flags stay put.
    directed_q.push_back(make_entry(STAT_ADR, OP_ALU, ALU_SUB, random_word(), 64'd5,
                                    64'd7, STAT_HLT, STAT_AOK));
    directed_q.push_back(make_entry(STAT_INS, OP_ALU, ALU_ADD, random_word(), WORD_ONES,
                                    WORD_ONES, STAT_AOK, STAT_INS));
    // Every icode once, the unused ones included.
    for (int op = 0; op < 16; op++) begin
      directed_q.push_back(make_entry(StatW'($urandom), CodeW'(op), CodeW'($urandom_range(0, 6)),
                                      random_word(), random_word(), random_word(),
                                      STAT_AOK, STAT_AOK));
    end

    // Beats go out in bursts; valid stays high across a burst and drops for
    // the gap that follows it. A zero gap joins two bursts.
    total      = directed_q.size() + RandomItems;
    burst_left = $urandom_range(0, 24);
    for (int n = 0; n < total; n++) begin
      item = (n < directed_q.size()) ? directed_q[n] : random_entry();
      s_axis_tdata  <= item;
      s_axis_tvalid <= 1'b1;
      do @(posedge clk_i); while (!s_axis_tready);
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(0, 24);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let the last accepted beat reach the monitor before draining.
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- y86_execute_stage_top.f -----
rtl/core/y86ex_pkg.sv
rtl/core/y86_execute_stage_top.sv
rtl/core/y86ex_checker.sv
tb/exec_stage_monitor.sv
tb/tb.sv
